// ----- rtl/core/mhpq_pkg.sv -----
// Shared types and codes for the max-heap priority queue.
// No dependencies; used by mhpq_cell and max_heap_priority_queue.
`default_nettype none

package mhpq_pkg;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 8;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } cell_op_t;

  // What a cell shows its right-hand neighbor.
  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic                     ahead;  // new value ranks ahead of this cell's entry
  } cell_link_t;

endpackage

`default_nettype wire

// ----- rtl/core/mhpq_cell.sv -----
// One slot of the sorted register chain behind the priority queue.
// Depends on mhpq_pkg.
`default_nettype none

module mhpq_cell (
  input  wire logic                             clk,
  input  wire mhpq_pkg::cell_op_t               op,
  input  wire logic signed [mhpq_pkg::DATA_W-1:0] value,
  input  wire logic                             occ,
  input  wire mhpq_pkg::cell_link_t             left_in,
  input  wire logic signed [mhpq_pkg::DATA_W-1:0] right_data,
  output mhpq_pkg::cell_link_t                  link_out
);
  import mhpq_pkg::*;

  logic signed [DATA_W-1:0] data;
  logic signed [DATA_W-1:0] data_next;
  logic                     ahead;

  // Empty slots rank below everything.
  assign ahead = !occ || (value > data);

  always_comb begin
    unique case (op)
      OP_INSERT: data_next = ahead ? (left_in.ahead ? left_in.data : value) : data;
      OP_REMOVE: data_next = right_data;
      default:   data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign link_out.data  = data;
  assign link_out.ahead = ahead;

endmodule

`default_nettype wire

// ----- rtl/core/max_heap_priority_queue.sv -----
// Top level of the signed 32-bit max priority queue.
// Depends on mhpq_pkg and mhpq_cell.
`default_nettype none

// Priority queue of up to CAPACITY signed 32-bit values. Each item on the
// slave side is a request: tuser = 0 inserts tdata, tuser = 1 removes and
// returns the largest value held. Every request yields exactly one result
// item: the removed maximum (zero for inserts and failed removes), a status
// in tuser (ok, insert dropped because full, remove on empty) and the count
// after the request. The entries live in a chain of CAPACITY cells kept in
// descending order; an insert compares the value in every cell at once and
// each cell either keeps its entry, takes the value, or takes its left
// neighbor's entry, while a remove shifts every entry one cell to the left.
// An accepted request updates the chain at the accepting edge, and its
// result sits in the output register from the next cycle.
// The block takes a new request every cycle while the output register is
// empty or being drained; a stalled output holds the slave side off.
// Results match a binary max-heap exactly, since only the maximum is ever read.

module max_heap_priority_queue #(
  parameter int CAPACITY = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request side
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] value_in
  input  wire logic        s_tuser,   // [0] cmd
  // result side
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [31:0] value_out, [39:32] count_out
  output logic [1:0]       m_tuser    // [1:0] status
);
  import mhpq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic          accept;
  cmd_t          cmd;
  logic          full;
  logic          empty;
  cell_op_t      op;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW+COUNT_W-1:0] count_ext;

  logic                     out_valid;
  logic signed [DATA_W-1:0] out_value;
  status_t                  out_status;
  logic [COUNT_W-1:0]       out_count;
  logic signed [DATA_W-1:0] res_value;
  status_t                  res_status;

  cell_link_t links [CAPACITY];

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign cmd      = cmd_t'(s_tuser);
  assign full     = (count == CW'(CAPACITY));
  assign empty    = (count == '0);

  // Chain operation and result for this request.
  always_comb begin
    op         = OP_HOLD;
    count_next = count;
    res_value  = '0;
    res_status = STAT_OK;
    if (accept) begin
      unique case (cmd)
        CMD_INSERT: begin
          if (full) begin
            res_status = STAT_FULL;
          end else begin
            op         = OP_INSERT;
            count_next = count + CW'(1);
          end
        end
        CMD_REMOVE: begin
          if (empty) begin
            res_status = STAT_EMPTY;
          end else begin
            op         = OP_REMOVE;
            res_value  = links[0].data;
            count_next = count - CW'(1);
          end
        end
        default: op = OP_HOLD;
      endcase
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      cell_link_t               left_in;
      logic signed [DATA_W-1:0] right_data;
      logic                     occ;

      assign occ = (CW'(i) < count);

      if (i == 0) begin : g_first
        assign left_in = '0;
      end else begin : g_mid
        assign left_in = links[i-1];
      end

      // Last cell refills with a don't-care on remove; it is then unoccupied.
      if (i == CAPACITY - 1) begin : g_last
        assign right_data = '0;
      end else begin : g_inner
        assign right_data = links[i+1].data;
      end

      mhpq_cell u_cell (
        .clk        (clk),
        .op         (op),
        .value      (signed'(s_tdata)),
        .occ        (occ),
        .left_in    (left_in),
        .right_data (right_data),
        .link_out   (links[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign count_ext = (CW + COUNT_W)'(count_next);

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value  <= res_value;
      out_status <= res_status;
      out_count  <= count_ext[COUNT_W-1:0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_count, out_value};
  assign m_tuser  = out_status;

  // Count never runs past the chain length.
  assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("count exceeds capacity");

  // A dropped insert leaves the occupancy alone.
  assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_INSERT && full |=> $stable(count) && m_tuser == STAT_FULL)
    else $error("full insert changed count");

  // Remove on an empty queue flags empty and returns zero.
  assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_REMOVE && empty |=>
      m_tuser == STAT_EMPTY && m_tdata[31:0] == '0 && count == '0)
    else $error("empty remove mishandled");

  // Head of the chain is never below its neighbor.
  assert property (@(posedge clk) disable iff (rst)
    count >= CW'(2) |-> links[0].data >= links[1].data)
    else $error("chain out of order");

endmodule

`default_nettype wire
